FILE: rtl/channel_occupancy_analyzer_defines.svh
// Assertion macros for the channel occupancy analyzer.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef CHANNEL_OCCUPANCY_ANALYZER_DEFINES_SVH
`define CHANNEL_OCCUPANCY_ANALYZER_DEFINES_SVH

// Check on every edge, reset included.
`define COA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Check outside reset only.
`define COA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

FILE: rtl/coa_pkg.sv
// Shared types, constants and helpers of the channel occupancy analyzer.
// No dependencies; imported by coa_divider and channel_occupancy_analyzer.
package coa_pkg;

  // Field widths
  localparam int unsigned HIT_W       = 5;
  localparam int unsigned CH_W        = 7;
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned QUIET_W     = 4;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned FS_W        = 8;
  localparam int unsigned DECAY_W     = 5;
  localparam int unsigned SWEEP_W     = 4;

  // Sweep totals and noise percentage
  localparam int unsigned HIT_TOTAL_W   = 12;
  localparam int unsigned HIT_TOTAL_MAX = 4095;
  localparam int unsigned PCT_SCALE     = 100;
  localparam int unsigned PCT_MAX       = 100;
  localparam int unsigned NUM_W         = 19;  // holds HIT_TOTAL_MAX * PCT_SCALE
  localparam int unsigned FS_MAX        = 255;

  // Band geometry: band k spans channels 9+5k .. 15+5k
  localparam int unsigned BAND_COUNT      = 13;
  localparam int unsigned BAND_SPACING    = 5;
  localparam int unsigned BAND_FIRST_LOW  = 9;
  localparam int unsigned BAND_TAPS       = 7;
  localparam int unsigned BAND_MEAN_SHIFT = 4;  // weights sum to 16
  localparam int unsigned BAND_W          = 4;
  localparam int unsigned TAP_W           = 3;
  localparam int unsigned WEIGHT_W        = 3;
  localparam int unsigned WSUM_W          = 9;

  // Register map and reset values
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 8'd1;
  localparam logic [FS_W-1:0]      FS_RESET       = 8'd30;
  localparam logic [DECAY_W-1:0]   DECAY_RESET    = 5'd4;
  localparam logic [DECAY_W-1:0]   DECAY_MAX      = 5'd16;

  typedef enum logic [1:0] {
    KIND_PEAK    = 2'd0,
    KIND_BAND    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef struct packed {
    logic busy;
    logic done;
  } coa_div_stat_t;

  // Weight 4 - |distance| for tap 0..6 of a band window.
  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [TAP_W-1:0] tap);
    logic [WEIGHT_W-1:0] w;
    case (tap) inside
      3'd0, 3'd6: w = 3'd1;
      3'd1, 3'd5: w = 3'd2;
      3'd2, 3'd4: w = 3'd3;
      3'd3:       w = 3'd4;
      default:    w = 3'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/coa_divider.sv
// Bit-serial restoring divider for the sweep noise percentage.
// Depends on coa_pkg; one quotient bit per cycle.
module coa_divider import coa_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 80
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [HIT_TOTAL_W-1:0] hit_total_i,
  input  logic [FS_W-1:0]        full_scale_i,
  output coa_div_stat_t          stat_o,
  output logic [PCT_W-1:0]       percent_o
);

  localparam int unsigned DenMax = NUM_CHANNELS * FS_MAX;
  localparam int unsigned DW     = $clog2(DenMax + 1);
  localparam int unsigned CW     = $clog2(NUM_W + 1);
  localparam logic [CW-1:0] CntLast = CW'(NUM_W - 1);

  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [FS_W-1:0]  fs_eff;
  logic [DW:0]      rem_sh;
  logic             ge;

  assign fs_eff = (full_scale_i == '0) ? FS_W'(1) : full_scale_i;
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      num_q  <= NUM_W'(NUM_W'(hit_total_i) * NUM_W'(PCT_SCALE));
      den_q  <= DW'(DW'(NUM_CHANNELS) * DW'(fs_eff));
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      // shift in next numerator bit, subtract when it fits
      rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      cnt_q <= CW'(cnt_q + CW'(1));
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign percent_o   = (quo_q > NUM_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quo_q[PCT_W-1:0];

endmodule

FILE: rtl/channel_occupancy_analyzer.sv
// Channel occupancy analyzer: per-channel peak hold, band levels, sweep summary.
// Depends on coa_pkg, coa_divider and channel_occupancy_analyzer_defines.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one channel hit count per
//   transaction, in sweep order; in_sweep_end_i marks the sweep's last channel.
//   Output channel (out_valid_o/out_ready_i) returns one peak-hold result per
//   input, plus 13 band results and one summary after a sweep-end input.
//   out_final_res_o flags the last result of each input.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; write it idle only.
// Sequence:
//   A channel input passes accept, peak read-modify-write and result load;
//   the result load waits while the output register is stalled. The next
//   input is taken while that result still waits in the output register.
//   A sweep-end input adds a band walk over the hit store, one read port:
//   per band 7 tap reads, a drain and a result load, then after all bands
//   the summary result; the noise divider runs alongside.
// Reset:
//   Peak holds read as zero through per-entry valid bits; sweep totals,
//   sweep counter and registers return to their defaults at once.
// Back-pressure: a stalled output register holds the walk in place; nothing
//   is dropped, and no new input is taken until the walk is done.
`include "channel_occupancy_analyzer_defines.svh"

module channel_occupancy_analyzer import coa_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 80,
  parameter int unsigned MAX_HITS     = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CH_W-1:0]       in_channel_i,
  input  logic [HIT_W-1:0]      in_hits_i,
  input  logic                  in_sweep_end_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [CH_W-1:0]       out_index_o,
  output logic [LEVEL_W-1:0]    out_level_o,
  output logic [PCT_W-1:0]      out_noise_percent_o,
  output logic [QUIET_W-1:0]    out_quiet_band_o,
  output logic                  out_final_res_o,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CH_AW = $clog2(NUM_CHANNELS);
  localparam logic [7:0]        NumChLim  = 8'(NUM_CHANNELS);
  localparam logic [7:0]        MaxHitLim = 8'(MAX_HITS);
  localparam logic [CH_AW-1:0]  BaseFirst = CH_AW'(BAND_FIRST_LOW);
  localparam logic [CH_AW-1:0]  BaseStep  = CH_AW'(BAND_SPACING);
  localparam logic [TAP_W-1:0]  TapLast   = TAP_W'(BAND_TAPS - 1);
  localparam logic [BAND_W-1:0] BandLast  = BAND_W'(BAND_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEAK,
    S_EMIT0,
    S_RD,
    S_FIN,
    S_BEMIT,
    S_SUM
  } state_e;

  state_e state_q;

  // captured input transaction
  logic [CH_W-1:0]  ch_q;
  logic [HIT_W-1:0] hits_q;
  logic             end_q;
  logic             in_range_q;
  logic [LEVEL_W-1:0] held_q;

  // sweep state and configuration
  logic [SWEEP_W-1:0]     sweep_cnt_q;
  logic [HIT_TOTAL_W-1:0] tot_q;
  logic [HIT_W-1:0]       str_val_q;
  logic [CH_W-1:0]        str_ch_q;
  logic [FS_W-1:0]        full_scale_q;
  logic [DECAY_W-1:0]     decay_q;

  // band walk
  logic [TAP_W-1:0]    tap_q;
  logic [BAND_W-1:0]   band_q;
  logic [CH_AW-1:0]    base_q;
  logic                hrd_pend_q;
  logic [WEIGHT_W-1:0] wt_q;
  logic [WSUM_W-1:0]   acc_q;
  logic [HIT_W-1:0]    mx_q;
  logic [WSUM_W-1:0]   best_q;
  logic [QUIET_W-1:0]  quiet_q;

  // output register
  logic               out_valid_q;
  kind_e              out_kind_q;
  logic [CH_W-1:0]    out_index_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic [PCT_W-1:0]   out_pct_q;
  logic [QUIET_W-1:0] out_quiet_q;
  logic               out_final_q;

  // memories
  logic [HIT_W-1:0] hit_mem [NUM_CHANNELS];
  logic [HIT_W-1:0] pk_mem  [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pk_vld_q;
  logic [HIT_W-1:0] hit_rd_q;
  logic [HIT_W-1:0] pk_rd_q;
  logic             pk_rd_vld_q;

  logic               in_acc;
  logic               in_range_c;
  logic [HIT_W-1:0]   hits_sat_c;
  logic [CH_AW-1:0]   in_idx;
  logic [CH_AW-1:0]   ch_idx;
  logic               out_free;
  logic               out_load;
  logic [DECAY_W-1:0] iv_eff;
  logic               decay_now;
  logic [HIT_W-1:0]   pk_cur;
  logic [HIT_W-1:0]   pk_new;
  logic [HIT_TOTAL_W:0] tot_sum;
  logic               hit_rd_en;
  logic [CH_AW-1:0]   hit_addr;
  logic [WSUM_W-1:0]  prod;
  logic [LEVEL_W-1:0] band_avg;
  logic [LEVEL_W-1:0] band_lvl;
  logic               div_start;
  coa_div_stat_t      div_stat;
  logic [PCT_W-1:0]   div_pct;

  // -------------------------------------------------------------------------
  // Handshake and input conditioning
  // -------------------------------------------------------------------------
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign in_range_c  = {1'b0, in_channel_i} < NumChLim;
  assign hits_sat_c  = ({3'b0, in_hits_i} > MaxHitLim) ? HIT_W'(MAX_HITS) : in_hits_i;
  assign in_idx      = in_channel_i[CH_AW-1:0];
  assign ch_idx      = ch_q[CH_AW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && ((state_q == S_EMIT0) || (state_q == S_BEMIT) ||
                                 ((state_q == S_SUM) && div_stat.done));

  // Decay interval clamps to 1..16; decay fires on the interval's last sweep.
  assign iv_eff = (decay_q == '0) ? DECAY_W'(1) :
                  (decay_q > DECAY_MAX) ? DECAY_MAX : decay_q;
  assign decay_now = (DECAY_W'(sweep_cnt_q) + DECAY_W'(1)) >= iv_eff;

  // Peak hold: rise at once, else fall by one on a decay sweep.
  assign pk_cur = pk_rd_vld_q ? pk_rd_q : '0;
  always_comb begin
    if (hits_q > pk_cur) begin
      pk_new = hits_q;
    end else if ((pk_cur != '0) && decay_now) begin
      pk_new = HIT_W'(pk_cur - HIT_W'(1));
    end else begin
      pk_new = pk_cur;
    end
  end

  assign tot_sum = {1'b0, tot_q} + (HIT_TOTAL_W + 1)'(hits_q);

  // Band walk datapath
  assign hit_rd_en = (state_q == S_RD);
  assign hit_addr  = CH_AW'(base_q + CH_AW'(tap_q));
  assign prod      = WSUM_W'(hit_rd_q) * WSUM_W'(wt_q);
  assign band_avg  = acc_q[WSUM_W-1:BAND_MEAN_SHIFT];
  assign band_lvl  = (mx_q > band_avg) ? mx_q : band_avg;

  // Kick the noise division once the sweep total is final.
  assign div_start = (state_q == S_EMIT0) && out_free && end_q;

  coa_divider #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .hit_total_i  (tot_q),
    .full_scale_i (full_scale_q),
    .stat_o       (div_stat),
    .percent_o    (div_pct)
  );

  // -------------------------------------------------------------------------
  // Memories: hit store written on accept, read by the band walk;
  // peak store read on accept, written back in the following cycle.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc && in_range_c) begin
      hit_mem[in_idx] <= hits_sat_c;
    end
    if (hit_rd_en) begin
      hit_rd_q <= hit_mem[hit_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range_c) begin
      pk_rd_q <= pk_mem[in_idx];
    end
    if ((state_q == S_PEAK) && in_range_q) begin
      pk_mem[ch_idx] <= pk_new;
    end
  end

  // Valid bits stand in for the all-zero reset of the peak store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_vld_q    <= '0;
      pk_rd_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pk_rd_vld_q <= in_range_c && pk_vld_q[in_idx];
      end
      if ((state_q == S_PEAK) && in_range_q) begin
        pk_vld_q[ch_idx] <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FS_RESET;
      decay_q      <= DECAY_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FULL_SCALE: full_scale_q <= cfg_data_i;
        REG_DECAY:      decay_q      <= cfg_data_i[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer, sweep state and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      hits_q      <= '0;
      end_q       <= 1'b0;
      in_range_q  <= 1'b0;
      held_q      <= '0;
      sweep_cnt_q <= '0;
      tot_q       <= '0;
      str_val_q   <= '0;
      str_ch_q    <= '0;
      tap_q       <= '0;
      band_q      <= '0;
      base_q      <= BaseFirst;
      hrd_pend_q  <= 1'b0;
      wt_q        <= '0;
      acc_q       <= '0;
      mx_q        <= '0;
      best_q      <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_PEAK;
      out_index_q <= '0;
      out_level_q <= '0;
      out_pct_q   <= '0;
      out_quiet_q <= '0;
      out_final_q <= 1'b0;
    end else begin
      // drop a taken result unless a new one loads this cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // accumulate the tap read issued last cycle
      hrd_pend_q <= hit_rd_en;
      if (hit_rd_en) begin
        wt_q <= tap_weight(tap_q);
      end
      if (hrd_pend_q) begin
        acc_q <= WSUM_W'(acc_q + prod);
        if (hit_rd_q > mx_q) begin
          mx_q <= hit_rd_q;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ch_q       <= in_channel_i;
            hits_q     <= hits_sat_c;
            end_q      <= in_sweep_end_i;
            in_range_q <= in_range_c;
            state_q    <= S_PEAK;
          end
        end

        S_PEAK: begin
          held_q <= in_range_q ? pk_new : '0;
          if (in_range_q) begin
            tot_q <= (tot_sum > (HIT_TOTAL_W + 1)'(HIT_TOTAL_MAX)) ?
                     HIT_TOTAL_W'(HIT_TOTAL_MAX) : tot_sum[HIT_TOTAL_W-1:0];
            if (hits_q > str_val_q) begin
              str_val_q <= hits_q;
              str_ch_q  <= ch_q;
            end
          end
          state_q <= S_EMIT0;
        end

        S_EMIT0: begin
          if (out_free) begin
            out_kind_q  <= KIND_PEAK;
            out_index_q <= ch_q;
            out_level_q <= held_q;
            out_pct_q   <= '0;
            out_quiet_q <= '0;
            out_final_q <= !end_q;
            if (end_q) begin
              tap_q   <= '0;
              band_q  <= '0;
              base_q  <= BaseFirst;
              acc_q   <= '0;
              mx_q    <= '0;
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_RD: begin
          tap_q <= TAP_W'(tap_q + TAP_W'(1));
          if (tap_q == TapLast) begin
            state_q <= S_FIN;
          end
        end

        S_FIN: begin
          // last tap lands in the accumulator this cycle
          state_q <= S_BEMIT;
        end

        S_BEMIT: begin
          if (out_free) begin
            out_kind_q  <= KIND_BAND;
            out_index_q <= CH_W'(band_q);
            out_level_q <= band_lvl;
            out_pct_q   <= '0;
            out_quiet_q <= '0;
            out_final_q <= 1'b0;
            // quietest band keeps the first of equal sums
            if ((band_q == '0) || (acc_q < best_q)) begin
              best_q  <= acc_q;
              quiet_q <= QUIET_W'(band_q + BAND_W'(1));
            end
            acc_q  <= '0;
            mx_q   <= '0;
            tap_q  <= '0;
            base_q <= CH_AW'(base_q + BaseStep);
            band_q <= BAND_W'(band_q + BAND_W'(1));
            state_q <= (band_q == BandLast) ? S_SUM : S_RD;
          end
        end

        S_SUM: begin
          if (out_free && div_stat.done) begin
            out_kind_q  <= KIND_SUMMARY;
            out_index_q <= str_ch_q;
            out_level_q <= str_val_q;
            out_pct_q   <= div_pct;
            out_quiet_q <= quiet_q;
            out_final_q <= 1'b1;
            // close the sweep
            tot_q       <= '0;
            str_val_q   <= '0;
            str_ch_q    <= '0;
            sweep_cnt_q <= decay_now ? '0 : SWEEP_W'(sweep_cnt_q + SWEEP_W'(1));
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_index_o         = out_index_q;
  assign out_level_o         = out_level_q;
  assign out_noise_percent_o = out_pct_q;
  assign out_quiet_band_o    = out_quiet_q;
  assign out_final_res_o     = out_final_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `COA_ASSERT(a_walk_addr_in_range, hit_rd_en |-> (8'(hit_addr) < NumChLim), "band walk read beyond the channel range")
  `COA_ASSERT(a_summary_is_final, (out_valid_o && (out_kind_o == KIND_SUMMARY)) |-> out_final_res_o, "summary without final flag")
  `COA_ASSERT(a_band_not_final, (out_valid_o && (out_kind_o == KIND_BAND)) |-> (!out_final_res_o && (out_index_o < CH_W'(BAND_COUNT))), "bad band result")
  `COA_ASSERT_ALWAYS(a_div_status, !(div_stat.busy && div_stat.done), "divider busy and done together")

endmodule
